// ===== hdl/lpnm_pkg.sv =====
`default_nettype none
package lpnm_pkg;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_POSE     = 2'd1,
    OP_MATCH    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_MAX_DIST = 3'd4
  } reg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [15:0]        box_min_x;
    logic [15:0]        box_min_y;
    logic [15:0]        box_max_x;
    logic [15:0]        box_max_y;
  } req_t;

  typedef struct packed {
    logic        matched;
    logic [3:0]  landmark_index;
    logic [31:0] dist_sq;
  } rsp_t;

  // divider status
  typedef struct packed {
    logic done;
    logic sat;
  } div_st_t;

  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;
  localparam int RM_W    = 22;
  localparam int CAM_W   = 43;
  localparam int NUM_W   = 59;
  localparam int DEN_W   = 42;
  localparam int QUO_W   = 19;
  localparam int DIV_SW  = DEN_W + QUO_W;
  localparam int DM_W    = 17;

  localparam logic [15:0] FOCAL_RST    = 16'd8000;
  localparam logic [15:0] CENTER_X_RST = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST = 16'd3840;
  localparam logic [15:0] MAX_DIST_RST = 16'd2400;
  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

endpackage
`default_nettype wire

// ===== hdl/lpnm_ram.sv =====
`default_nettype none
module lpnm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/lpnm_div.sv =====
`default_nettype none
module lpnm_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lpnm_pkg::NUM_W-1:0]      num,
  input  logic [lpnm_pkg::DEN_W-1:0]      den,
  output lpnm_pkg::div_st_t               st,
  output logic [lpnm_pkg::QUO_W-1:0]      quo
);

  localparam int SW    = lpnm_pkg::DIV_SW;
  localparam int QW    = lpnm_pkg::QUO_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             sat_r, sat_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [SW-1:0]    dsh_r, dsh_nxt;
  logic [QW-1:0]    q_r, q_nxt;

  // restoring division, one quotient bit a cycle; a quotient that does not fit in QW bits sets sat
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      rem_nxt = SW'(num);
      dsh_nxt = SW'(den) << (QW - 1);
      q_nxt   = '0;
      cnt_nxt = CNT_W'(QW);
      if (SW'(num) >= (SW'(den) << QW)) begin
        sat_nxt  = 1'b1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        sat_nxt  = 1'b0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      sat_r  <= sat_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign st.done = done_r;
  assign st.sat  = sat_r;
  assign quo     = q_r;

endmodule
`default_nettype wire

// ===== hdl/projected_landmark_nearest_match_unit.sv =====
`default_nettype none
// append and pose requests finish in the cycle they are taken; busy stays low
// match: quaternion products and rotation matrix as setup, then per landmark the
// camera transform, plus two divides when it lies in front of the camera, then the
// result strobe; one request at a time, busy high meanwhile
// result strobe lasts one cycle, the receiver cannot stall
// rst_n synchronous active low: empty table, identity pose, default intrinsics
module projected_landmark_nearest_match_unit #(
  parameter int MAX_LANDMARKS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  lpnm_pkg::req_t                     in_req,
  output logic                               out_valid,
  output lpnm_pkg::rsp_t                     out_rsp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpnm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  localparam int IW   = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CNTW = $clog2(MAX_LANDMARKS + 1);
  localparam int IXW  = (IW > 4) ? IW : 4;
  localparam int AW   = lpnm_pkg::MUL_A_W;
  localparam int BW   = lpnm_pkg::MUL_B_W;
  localparam int PW   = lpnm_pkg::MUL_P_W;
  localparam int XW   = lpnm_pkg::ACC_W;
  localparam int RW   = lpnm_pkg::RM_W;
  localparam int CW   = lpnm_pkg::CAM_W;
  localparam int DMW  = lpnm_pkg::DM_W;

  // sequencer states
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_QMUL   = 14'b00000000000010,
    S_RMAT   = 14'b00000000000100,
    S_LOAD   = 14'b00000000001000,
    S_CMAC   = 14'b00000000010000,
    S_CSTORE = 14'b00000000100000,
    S_CHECK  = 14'b00000001000000,
    S_PMUL   = 14'b00000010000000,
    S_DIVST  = 14'b00000100000000,
    S_DIVW   = 14'b00001000000000,
    S_SQR    = 14'b00010000000000,
    S_CMP    = 14'b00100000000000,
    S_NEXT   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  // indexes of the quaternion products
  localparam int P_YY = 0, P_ZZ = 1, P_XX = 2, P_XY = 3, P_WZ = 4;
  localparam int P_XZ = 5, P_WY = 6, P_YZ = 7, P_WX = 8;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] fx_r, fy_r, cx_r, cy_r, md_r;

  // pose and table fill
  logic [CNTW-1:0]    lm_count_r, lm_count_nxt;
  logic signed [31:0] tr_r [3];
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;

  // datapath state
  logic signed [31:0] qp_r [9];
  logic signed [RW-1:0] rm_r [3][3];
  logic signed [RW-1:0] rm_nxt [3][3];
  logic signed [CW-1:0] cam_r [3];
  logic signed [CW-1:0] cam_nxt [3];
  logic [DMW-1:0]       dm_r [2];
  logic [DMW-1:0]       dm_nxt [2];
  logic signed [XW-1:0] acc_r, acc_nxt;
  logic [31:0]          best_r, best_nxt;
  logic                 found_r, found_nxt;
  logic [IXW-1:0]       bidx_r, bidx_nxt;
  logic [CNTW-1:0]      idx_r, idx_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [1:0]           row_r, row_nxt;
  logic [1:0]           col_r, col_nxt;
  logic                 axis_r, axis_nxt;
  logic [15:0]          cu_r, cv_r;
  logic                 out_valid_r, out_valid_nxt;
  lpnm_pkg::rsp_t       out_rsp_r, out_rsp_nxt;

  logic accept;
  assign accept = start && (state_r == S_IDLE);

  // landmark table, {z, y, x}
  logic          ram_we;
  logic [95:0]   ram_rdata;
  logic signed [31:0] lm_p [3];

  assign ram_we = accept && (in_req.operation == 2'(lpnm_pkg::OP_APPEND)) &&
                  (lm_count_r < CNTW'(MAX_LANDMARKS));

  lpnm_ram #(
    .WIDTH (96),
    .DEPTH (MAX_LANDMARKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lm_count_r[IW-1:0]),
    .wdata ({in_req.pos_z, in_req.pos_y, in_req.pos_x}),
    .raddr (idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign lm_p[0] = ram_rdata[31:0];
  assign lm_p[1] = ram_rdata[63:32];
  assign lm_p[2] = ram_rdata[95:64];

  // shared multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [XW-1:0] mul_px;
  assign mul_p  = mul_a * mul_b;
  assign mul_px = XW'(mul_p);

  // rotation matrix entries, Q.28 then floored to Q.14
  logic signed [35:0] rot_e [3][3];
  logic signed [35:0] qpe [9];
  localparam logic signed [35:0] ROT_ONE = 36'sd268435456;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qpe[k] = 36'(qp_r[k]);
    end
    rot_e[0][0] = ROT_ONE - ((qpe[P_YY] + qpe[P_ZZ]) <<< 1);
    rot_e[0][1] = (qpe[P_XY] - qpe[P_WZ]) <<< 1;
    rot_e[0][2] = (qpe[P_XZ] + qpe[P_WY]) <<< 1;
    rot_e[1][0] = (qpe[P_XY] + qpe[P_WZ]) <<< 1;
    rot_e[1][1] = ROT_ONE - ((qpe[P_XX] + qpe[P_ZZ]) <<< 1);
    rot_e[1][2] = (qpe[P_YZ] - qpe[P_WX]) <<< 1;
    rot_e[2][0] = (qpe[P_XZ] - qpe[P_WY]) <<< 1;
    rot_e[2][1] = (qpe[P_YZ] + qpe[P_WX]) <<< 1;
    rot_e[2][2] = ROT_ONE - ((qpe[P_XX] + qpe[P_YY]) <<< 1);
  end

  // divider hookup
  lpnm_pkg::div_st_t                 div_st;
  logic [lpnm_pkg::QUO_W-1:0]        div_quo;
  logic signed [XW-1:0]              acc_abs;
  assign acc_abs = acc_r[XW-1] ? -acc_r : acc_r;

  lpnm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVST),
    .num   (acc_abs[lpnm_pkg::NUM_W-1:0]),
    .den   (cam_r[2][lpnm_pkg::DEN_W-1:0]),
    .st    (div_st),
    .quo   (div_quo)
  );

  // camera coordinate of the current axis, split for the focal multiply
  logic signed [CW-1:0] cam_sel;
  assign cam_sel = axis_r ? cam_r[1] : cam_r[0];

  // pixel difference from the divided quotient, clamped to 1<<16
  logic [19:0]          q_mag;
  logic signed [20:0]   q_sgn;
  logic signed [21:0]   pix_diff;
  logic [21:0]          pix_mag;
  logic [DMW-1:0]       pix_clamp;
  logic [15:0]          ctr_sel, cen_sel;

  assign ctr_sel   = axis_r ? cy_r : cx_r;
  assign cen_sel   = axis_r ? cv_r : cu_r;
  assign q_mag     = div_st.sat ? 20'h80000 : {1'b0, div_quo};
  assign q_sgn     = cam_sel[CW-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign pix_diff  = 22'(q_sgn) + $signed({6'b0, ctr_sel}) - $signed({6'b0, cen_sel});
  assign pix_mag   = pix_diff[21] ? 22'(-pix_diff) : 22'(pix_diff);
  assign pix_clamp = (pix_mag > 22'd65536) ? 17'h10000 : pix_mag[DMW-1:0];

  // squared distance, saturated to 32 bits
  logic [31:0] dist_sat;
  assign dist_sat = (acc_r[XW-1:32] != '0) ? 32'hFFFF_FFFF : acc_r[31:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_QMUL: begin
        case (step_r)
          4'd0:    begin mul_a = AW'(qy_r); mul_b = BW'(qy_r); end
          4'd1:    begin mul_a = AW'(qz_r); mul_b = BW'(qz_r); end
          4'd2:    begin mul_a = AW'(qx_r); mul_b = BW'(qx_r); end
          4'd3:    begin mul_a = AW'(qx_r); mul_b = BW'(qy_r); end
          4'd4:    begin mul_a = AW'(qw_r); mul_b = BW'(qz_r); end
          4'd5:    begin mul_a = AW'(qx_r); mul_b = BW'(qz_r); end
          4'd6:    begin mul_a = AW'(qw_r); mul_b = BW'(qy_r); end
          4'd7:    begin mul_a = AW'(qy_r); mul_b = BW'(qz_r); end
          4'd8:    begin mul_a = AW'(qw_r); mul_b = BW'(qx_r); end
          default: begin
            // match radius squared
            mul_a = $signed({6'b0, md_r});
            mul_b = $signed({17'b0, md_r});
          end
        endcase
      end
      S_CMAC: begin
        mul_a = rm_r[row_r][col_r];
        mul_b = BW'(lm_p[col_r]);
      end
      S_PMUL: begin
        mul_a = $signed({6'b0, (axis_r ? fy_r : fx_r)});
        if (step_r == 4'd0) begin
          // upper part carries the sign of the coordinate
          mul_b = BW'($signed(cam_sel[CW-1:21]));
        end else begin
          mul_b = $signed({12'b0, cam_sel[20:0]});
        end
      end
      S_SQR: begin
        mul_a = $signed({5'b0, dm_r[step_r[0]]});
        mul_b = $signed({16'b0, dm_r[step_r[0]]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    lm_count_nxt  = lm_count_r;
    rm_nxt        = rm_r;
    cam_nxt       = cam_r;
    dm_nxt        = dm_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    bidx_nxt      = bidx_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    axis_nxt      = axis_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    unique case (state_r)
      S_IDLE: begin
        if (ram_we) begin
          lm_count_nxt = lm_count_r + CNTW'(1);
        end
        if (accept && (in_req.operation == 2'(lpnm_pkg::OP_MATCH))) begin
          state_nxt = S_QMUL;
          step_nxt  = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          bidx_nxt  = '0;
        end
      end
      S_QMUL: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd9) begin
          best_nxt  = mul_p[31:0];
          state_nxt = S_RMAT;
        end
      end
      S_RMAT: begin
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            rm_nxt[a][b] = RW'(rot_e[a][b] >>> 14);
          end
        end
        row_nxt = '0;
        col_nxt = '0;
        if (lm_count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // table read data settles for the new index
        state_nxt = S_CMAC;
      end
      S_CMAC: begin
        acc_nxt = ((col_r == 2'd0) ? '0 : acc_r) + mul_px;
        if (col_r == 2'd2) begin
          col_nxt   = '0;
          state_nxt = S_CSTORE;
        end else begin
          col_nxt = col_r + 2'd1;
        end
      end
      S_CSTORE: begin
        cam_nxt[row_r] = CW'(acc_r >>> 14) + CW'(tr_r[row_r]);
        if (row_r == 2'd2) begin
          row_nxt   = '0;
          state_nxt = S_CHECK;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = S_CMAC;
        end
      end
      S_CHECK: begin
        // skip landmarks on or behind the image plane
        step_nxt = '0;
        axis_nxt = 1'b0;
        if (cam_r[2][CW-1] || (cam_r[2] == '0)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        if (step_r == 4'd0) begin
          acc_nxt  = mul_px <<< 21;
          step_nxt = 4'd1;
        end else begin
          acc_nxt   = acc_r + mul_px;
          state_nxt = S_DIVST;
        end
      end
      S_DIVST: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_st.done) begin
          dm_nxt[axis_r] = pix_clamp;
          step_nxt       = '0;
          if (!axis_r) begin
            axis_nxt  = 1'b1;
            state_nxt = S_PMUL;
          end else begin
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (step_r == 4'd0) begin
          acc_nxt  = mul_px;
          step_nxt = 4'd1;
        end else begin
          acc_nxt   = acc_r + mul_px;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // strict compare keeps the lowest index on a tie
        if (dist_sat < best_r) begin
          best_nxt  = dist_sat;
          found_nxt = 1'b1;
          bidx_nxt  = IXW'(idx_r);
        end
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if ((idx_r + CNTW'(1)) < lm_count_r) begin
          idx_nxt   = idx_r + CNTW'(1);
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt              = 1'b1;
        out_rsp_nxt.matched        = found_r;
        out_rsp_nxt.landmark_index = found_r ? bidx_r[3:0] : 4'd0;
        out_rsp_nxt.dist_sq        = found_r ? best_r : 32'd0;
        state_nxt                  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and pose registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lm_count_r  <= '0;
      out_valid_r <= 1'b0;
      fx_r        <= lpnm_pkg::FOCAL_RST;
      fy_r        <= lpnm_pkg::FOCAL_RST;
      cx_r        <= lpnm_pkg::CENTER_X_RST;
      cy_r        <= lpnm_pkg::CENTER_Y_RST;
      md_r        <= lpnm_pkg::MAX_DIST_RST;
      tr_r[0]     <= '0;
      tr_r[1]     <= '0;
      tr_r[2]     <= '0;
      qw_r        <= lpnm_pkg::QUAT_ONE;
      qx_r        <= '0;
      qy_r        <= '0;
      qz_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      lm_count_r  <= lm_count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (lpnm_pkg::reg_t'(cfg_index))
          lpnm_pkg::REG_FOCAL_X:  fx_r <= cfg_data;
          lpnm_pkg::REG_FOCAL_Y:  fy_r <= cfg_data;
          lpnm_pkg::REG_CENTER_X: cx_r <= cfg_data;
          lpnm_pkg::REG_CENTER_Y: cy_r <= cfg_data;
          lpnm_pkg::REG_MAX_DIST: md_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && (in_req.operation == 2'(lpnm_pkg::OP_POSE))) begin
        tr_r[0] <= in_req.pos_x;
        tr_r[1] <= in_req.pos_y;
        tr_r[2] <= in_req.pos_z;
        qw_r    <= in_req.rot_w;
        qx_r    <= in_req.rot_x;
        qy_r    <= in_req.rot_y;
        qz_r    <= in_req.rot_z;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == S_QMUL) && (step_r != 4'd9)) begin
      qp_r[step_r] <= mul_p[31:0];
    end
    if (accept) begin
      // detection centre, rounded down
      cu_r <= 16'(({1'b0, in_req.box_min_x} + {1'b0, in_req.box_max_x}) >> 1);
      cv_r <= 16'(({1'b0, in_req.box_min_y} + {1'b0, in_req.box_max_y}) >> 1);
    end
    rm_r      <= rm_nxt;
    cam_r     <= cam_nxt;
    dm_r      <= dm_nxt;
    acc_r     <= acc_nxt;
    best_r    <= best_nxt;
    found_r   <= found_nxt;
    bidx_r    <= bidx_nxt;
    idx_r     <= idx_nxt;
    step_r    <= step_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    axis_r    <= axis_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign cfg_ready = 1'b1;

  // a result only appears once the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  // table fill never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    lm_count_r <= CNTW'(MAX_LANDMARKS))
    else $error("landmark count beyond capacity");

  // unmatched result carries zero index and distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.matched) |->
      (out_rsp.landmark_index == 4'd0) && (out_rsp.dist_sq == 32'd0))
    else $error("unmatched result not zeroed");

  // a match request always starts the sequencer
  a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.operation == 2'(lpnm_pkg::OP_MATCH))) |=> busy)
    else $error("match request did not start");

  // divider completes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIVW))
    else $error("divider done outside wait state");

endmodule
`default_nettype wire
